>>> hdl/pcpd_pkg.sv
// shared types and constants of the picture column post decoder
// commands, queue operation codes, register indexes and the front-to-back queue entry
// no dependencies
package pcpd_pkg;

    // input commands
    localparam logic [1:0] CMD_LOAD_SHADE = 2'd0;
    localparam logic [1:0] CMD_LOAD_COLOR = 2'd1;
    localparam logic [1:0] CMD_START      = 2'd2;
    localparam logic [1:0] CMD_BYTE       = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_PALETTE_SELECT = 2'd0;
    localparam logic [1:0] REG_LIGHT_LEVEL    = 2'd1;
    localparam logic [1:0] REG_SPRITE_WIDTH   = 2'd2;
    localparam logic [1:0] REG_SPRITE_HEIGHT  = 2'd3;

    // start-row byte that closes a column
    localparam logic [7:0] END_MARKER = 8'hFF;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // work handed from front to back
    typedef enum logic [1:0] {
        OP_LOAD_SHADE,
        OP_LOAD_COLOR,
        OP_PIXEL,
        OP_COLUMN_END
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [13:0] table_index;
        logic [23:0] table_value;
        logic [7:0]  pixel_byte;
        logic [9:0]  row;
        logic [8:0]  column;
    } queue_entry_t;

    typedef struct packed {
        logic         push;
        queue_entry_t entry;
    } queue_push_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> hdl/pcpd_front.sv
// front part: accepts input transactions, parses the post stream and classifies work
// depends on pcpd_pkg; feeds pcpd_queue
module pcpd_front
    import pcpd_pkg::*;
#(
    parameter int LIGHT_LEVELS = 64,
    parameter int PALETTES     = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    command,
    input  logic [13:0]   table_index,
    input  logic [23:0]   table_value,
    input  logic [8:0]    column_index,
    input  logic [7:0]    data_byte,
    input  logic [9:0]    width_eff,
    input  logic [9:0]    sprite_height,
    input  queue_status_t q_status,
    output queue_push_t   q_push
);

    localparam int SHADE_DEPTH = LIGHT_LEVELS * 256;
    localparam int COLOR_DEPTH = PALETTES * 256;

    // parse phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_START    = 3'd1;
    localparam logic [2:0] PH_LENGTH   = 3'd2;
    localparam logic [2:0] PH_PAD_PRE  = 3'd3;
    localparam logic [2:0] PH_PIXELS   = 3'd4;
    localparam logic [2:0] PH_PAD_POST = 3'd5;

    logic [2:0] phase_reg, phase_next;
    logic [9:0] row_reg, row_next;
    logic [7:0] run_reg, run_next;
    logic [8:0] column_reg, column_next;
    logic [7:0] run_dec;
    logic       accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign run_dec  = run_reg - 8'd1;

    // parse step and classification
    always_comb
    begin
        phase_next  = phase_reg;
        row_next    = row_reg;
        run_next    = run_reg;
        column_next = column_reg;

        q_push.push              = 1'b0;
        q_push.entry.op          = OP_PIXEL;
        q_push.entry.table_index = table_index;
        q_push.entry.table_value = table_value;
        q_push.entry.pixel_byte  = data_byte;
        q_push.entry.row         = row_reg;
        q_push.entry.column      = column_reg;

        if (accept)
        begin
            unique case (command)
                CMD_LOAD_SHADE:
                begin
                    q_push.entry.op = OP_LOAD_SHADE;
                    q_push.push     = (32'(table_index) < SHADE_DEPTH);
                end
                CMD_LOAD_COLOR:
                begin
                    q_push.entry.op = OP_LOAD_COLOR;
                    q_push.push     = (32'(table_index) < COLOR_DEPTH);
                end
                CMD_START:
                begin
                    column_next = column_index;
                    row_next    = 10'd0;
                    run_next    = 8'd0;
                    phase_next  = PH_START;
                end
                CMD_BYTE:
                begin
                    unique case (phase_reg)
                        PH_START:
                        begin
                            if (data_byte == END_MARKER)
                            begin
                                q_push.entry.op = OP_COLUMN_END;
                                q_push.push     = 1'b1;
                                phase_next      = PH_IDLE;
                            end
                            else
                            begin
                                row_next   = {2'b00, data_byte};
                                phase_next = PH_LENGTH;
                            end
                        end
                        PH_LENGTH:
                        begin
                            run_next   = data_byte;
                            phase_next = PH_PAD_PRE;
                        end
                        PH_PAD_PRE:
                        begin
                            phase_next = (run_reg != 8'd0) ? PH_PIXELS : PH_PAD_POST;
                        end
                        PH_PIXELS:
                        begin
                            // pixels outside the sprite are consumed silently
                            q_push.entry.op = OP_PIXEL;
                            q_push.push     = (row_reg < sprite_height) &&
                                              ({1'b0, column_reg} < width_eff);
                            row_next        = row_reg + 10'd1;
                            run_next        = run_dec;
                            if (run_dec == 8'd0)
                            begin
                                phase_next = PH_PAD_POST;
                            end
                        end
                        PH_PAD_POST:
                        begin
                            phase_next = PH_START;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            row_reg    <= 10'd0;
            run_reg    <= 8'd0;
            column_reg <= 9'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            row_reg    <= row_next;
            run_reg    <= run_next;
            column_reg <= column_next;
        end
    end

endmodule

>>> hdl/pcpd_queue.sv
// short queue between the parsing front and the table back
// depends on pcpd_pkg
module pcpd_queue
    import pcpd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_push_t   q_push,
    input  logic          pop,
    output queue_head_t   q_head,
    output queue_status_t q_status
);

    queue_entry_t          entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign q_status.full  = (32'(count_reg) == QUEUE_DEPTH);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = q_push.push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;

    assign q_head.valid = !q_status.empty;
    assign q_head.entry = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

>>> hdl/pcpd_back.sv
// back part: table loads, colormap and palette lookups, address arithmetic, output register
// depends on pcpd_pkg; takes work from pcpd_queue
module pcpd_back
    import pcpd_pkg::*;
#(
    parameter int LIGHT_LEVELS = 64,
    parameter int PALETTES     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t q_head,
    output logic        pop,
    input  logic [3:0]  palette_select,
    input  logic [5:0]  light_level,
    input  logic [9:0]  width_eff,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [17:0] pixel_address,
    output logic [23:0] pixel_color,
    output logic        pixel_valid,
    output logic        column_end
);

    localparam int SHADE_DEPTH = LIGHT_LEVELS * 256;
    localparam int COLOR_DEPTH = PALETTES * 256;
    localparam int SHADE_AW    = $clog2(SHADE_DEPTH);
    localparam int COLOR_AW    = $clog2(COLOR_DEPTH);

    logic [7:0]  shade_mem [SHADE_DEPTH];
    logic [23:0] color_mem [COLOR_DEPTH];

    logic                adv;
    logic [7:0]          level_eff;
    logic [7:0]          palette_eff;
    logic [15:0]         shade_rd_full;
    logic [15:0]         color_rd_full;
    logic [15:0]         tidx_ext;
    logic [SHADE_AW-1:0] shade_rd_addr;
    logic [SHADE_AW-1:0] shade_wr_addr;
    logic [COLOR_AW-1:0] color_rd_addr;
    logic [COLOR_AW-1:0] color_wr_addr;
    logic [19:0]         product;
    logic [19:0]         addr_sum;
    logic                result_op;

    // stage 1: shade read and row multiply
    logic        s1_valid_reg;
    logic        s1_end_reg;
    logic [19:0] s1_prod_reg;
    logic [8:0]  s1_col_reg;
    logic [7:0]  shade_rd_reg;
    // stage 2: color read and address sum
    logic        s2_valid_reg;
    logic        s2_end_reg;
    logic [17:0] s2_addr_reg;
    logic [23:0] color_rd_reg;
    // output register
    logic        out_valid_reg;
    logic [17:0] out_addr_reg;
    logic [23:0] out_color_reg;
    logic        out_pix_reg;
    logic        out_end_reg;

    // whole back moves together unless the output is held
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && q_head.valid;

    // selectors beyond the table count use the last level or palette
    assign level_eff   = (32'(light_level) >= LIGHT_LEVELS) ? 8'(LIGHT_LEVELS - 1)
                                                            : {2'b00, light_level};
    assign palette_eff = (32'(palette_select) >= PALETTES) ? 8'(PALETTES - 1)
                                                           : {4'b0000, palette_select};

    assign shade_rd_full = {level_eff, q_head.entry.pixel_byte};
    assign color_rd_full = {palette_eff, shade_rd_reg};
    assign tidx_ext      = {2'b00, q_head.entry.table_index};
    assign shade_rd_addr = shade_rd_full[SHADE_AW-1:0];
    assign color_rd_addr = color_rd_full[COLOR_AW-1:0];
    assign shade_wr_addr = tidx_ext[SHADE_AW-1:0];
    assign color_wr_addr = tidx_ext[COLOR_AW-1:0];

    assign product   = 20'(q_head.entry.row) * 20'(width_eff);
    assign addr_sum  = s1_prod_reg + 20'(s1_col_reg);
    assign result_op = (q_head.entry.op == OP_PIXEL) || (q_head.entry.op == OP_COLUMN_END);

    // colormap memory
    always_ff @(posedge clk)
    begin
        if (pop && q_head.entry.op == OP_LOAD_SHADE)
        begin
            shade_mem[shade_wr_addr] <= q_head.entry.table_value[7:0];
        end
        if (adv)
        begin
            shade_rd_reg <= shade_mem[shade_rd_addr];
        end
    end

    // palette memory
    always_ff @(posedge clk)
    begin
        if (pop && q_head.entry.op == OP_LOAD_COLOR)
        begin
            color_mem[color_wr_addr] <= q_head.entry.table_value;
        end
        if (adv)
        begin
            color_rd_reg <= color_mem[color_rd_addr];
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop && result_op;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_end_reg  <= (q_head.entry.op == OP_COLUMN_END);
            s1_prod_reg <= product;
            s1_col_reg  <= q_head.entry.column;
            s2_end_reg  <= s1_end_reg;
            s2_addr_reg <= addr_sum[17:0];
            if (s2_end_reg)
            begin
                out_addr_reg  <= 18'd0;
                out_color_reg <= 24'd0;
                out_pix_reg   <= 1'b0;
                out_end_reg   <= 1'b1;
            end
            else
            begin
                out_addr_reg  <= s2_addr_reg;
                out_color_reg <= color_rd_reg;
                out_pix_reg   <= 1'b1;
                out_end_reg   <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_address = out_addr_reg;
    assign pixel_color   = out_color_reg;
    assign pixel_valid   = out_pix_reg;
    assign column_end    = out_end_reg;

endmodule

>>> hdl/picture_column_post_decoder.sv
// Sprite column post decoder: takes one command or raw column byte per transaction and emits
// a pixel write (linear address and RGB colour) or a column-end transaction. The sustained rate
// is one input transaction per clock cycle while the output side keeps taking results; a
// result passes through the queue, the colormap read, the palette read and the output
// register. A four-entry queue parts the parsing front from the lookup back, so input keeps
// flowing while the output is held, until the queue is full. Both tables power up undefined
// and must be loaded before pixels use them; there is no clearing pass. The user must write
// configuration through the cfg channel only while the block is idle; the block does not check.
// depends on pcpd_pkg, pcpd_front, pcpd_queue, pcpd_back
module picture_column_post_decoder
    import pcpd_pkg::*;
#(
    parameter int MAX_WIDTH    = 512,
    parameter int LIGHT_LEVELS = 64,
    parameter int PALETTES     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [13:0] table_index,
    input  logic [23:0] table_value,
    input  logic [8:0]  column_index,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [17:0] pixel_address,
    output logic [23:0] pixel_color,
    output logic        pixel_valid,
    output logic        column_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    logic [3:0]    palette_select_reg;
    logic [5:0]    light_level_reg;
    logic [9:0]    sprite_width_reg;
    logic [9:0]    sprite_height_reg;
    logic [9:0]    width_eff;
    queue_push_t   q_push;
    queue_head_t   q_head;
    queue_status_t q_status;
    logic          pop;

    assign cfg_ready = 1'b1;

    // width saturates at the largest supported sprite
    assign width_eff = (32'(sprite_width_reg) > MAX_WIDTH) ? 10'(MAX_WIDTH) : sprite_width_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_select_reg <= 4'd0;
            light_level_reg    <= 6'd0;
            sprite_width_reg   <= 10'd1;
            sprite_height_reg  <= 10'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PALETTE_SELECT: palette_select_reg <= cfg_data[3:0];
                REG_LIGHT_LEVEL:    light_level_reg    <= cfg_data[5:0];
                REG_SPRITE_WIDTH:   sprite_width_reg   <= cfg_data;
                REG_SPRITE_HEIGHT:  sprite_height_reg  <= cfg_data;
            endcase
        end
    end

    pcpd_front #(
        .LIGHT_LEVELS (LIGHT_LEVELS),
        .PALETTES     (PALETTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .table_index   (table_index),
        .table_value   (table_value),
        .column_index  (column_index),
        .data_byte     (data_byte),
        .width_eff     (width_eff),
        .sprite_height (sprite_height_reg),
        .q_status      (q_status),
        .q_push        (q_push)
    );

    pcpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .q_head   (q_head),
        .q_status (q_status)
    );

    pcpd_back #(
        .LIGHT_LEVELS (LIGHT_LEVELS),
        .PALETTES     (PALETTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_head         (q_head),
        .pop            (pop),
        .palette_select (palette_select_reg),
        .light_level    (light_level_reg),
        .width_eff      (width_eff),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_address  (pixel_address),
        .pixel_color    (pixel_color),
        .pixel_valid    (pixel_valid),
        .column_end     (column_end)
    );

    // a result is either a pixel write or a column end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_valid ^ column_end))
        else $error("result is neither a pixel nor a column end");

    // column end carries zero address and colour
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && column_end) |-> (pixel_address == 18'd0 && pixel_color == 24'd0))
        else $error("column end with non-zero pixel fields");

    // queue cannot be full and empty together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
